>>> hw/rtl/lswc_pkg.sv
`default_nettype none
package lswc_pkg;

  localparam int unsigned CoordWidthDefault = 16;
  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned ApbAddrWidth = 4;
  localparam int unsigned ApbDataWidth = 32;

  // byte addresses of the window registers
  localparam logic [ApbAddrWidth-1:0] AddrWinLeft   = 4'h0;
  localparam logic [ApbAddrWidth-1:0] AddrWinBottom = 4'h4;
  localparam logic [ApbAddrWidth-1:0] AddrWinRight  = 4'h8;
  localparam logic [ApbAddrWidth-1:0] AddrWinTop    = 4'hC;

  // outcode bit positions
  localparam int unsigned OcLeft  = 0;
  localparam int unsigned OcRight = 1;
  localparam int unsigned OcBelow = 2;
  localparam int unsigned OcAbove = 3;

  typedef enum logic [1:0] {
    StatusInside  = 2'd0,
    StatusReject  = 2'd1,
    StatusClipped = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    BackIdle,
    BackScan,
    BackMul,
    BackSum,
    BackDiv,
    BackOut
  } back_state_e;

endpackage
`default_nettype wire

>>> hw/rtl/lswc_in_if.sv
`default_nettype none
interface lswc_in_if #(
  parameter int unsigned CoordWidth = lswc_pkg::CoordWidthDefault
);
  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] start_x;
  logic signed [CoordWidth-1:0] start_y;
  logic signed [CoordWidth-1:0] end_x;
  logic signed [CoordWidth-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lswc_out_if.sv
`default_nettype none
interface lswc_out_if #(
  parameter int unsigned CoordWidth = lswc_pkg::CoordWidthDefault
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic signed [CoordWidth-1:0] clipped_start_x;
  logic signed [CoordWidth-1:0] clipped_start_y;
  logic signed [CoordWidth-1:0] clipped_end_x;
  logic signed [CoordWidth-1:0] clipped_end_y;

  modport source (output valid, status, clipped_start_x, clipped_start_y, clipped_end_x,
                  clipped_end_y, input ready);
  modport sink (input valid, status, clipped_start_x, clipped_start_y, clipped_end_x,
                clipped_end_y, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/line_segment_window_clipper_unit.sv
// Line segment clipper against a rectangular window (Cohen-Sutherland outcodes).
// in_chan carries one segment word (start_x, start_y, end_x, end_y); out_chan
// carries one result word per segment, in order: status plus the clipped end points.
// The window bounds sit in four APB registers at byte addresses 0, 4, 8 and 12
// (left, bottom, right, top), reset to 0; the user must write them only while idle,
// the block does not enforce it. A classifier accepts a word per cycle into a
// four-deep queue while it has room; a sequencer behind it finishes each word.
// Segments that lie fully inside or are rejected outright pass the queue and the
// output register, one per cycle while the sequencer is idle and the receiver takes
// them. A clipped segment walks each end point over up to four window edges; every
// move uses a shared multiplier stage and a restoring divider that retires one
// quotient bit a cycle, passing through the Mul, Sum and Div states in order.
// The divider sets the rate for clipped segments.
// Results sit in an output register; a stalled receiver holds it, the queue keeps
// taking words until full, then in_chan.ready drops. Reset empties the queue and
// drops out_chan.valid.
`default_nettype none
module line_segment_window_clipper_unit #(
  parameter int unsigned COORD_WIDTH = lswc_pkg::CoordWidthDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  lswc_in_if.sink                                in_chan,
  lswc_out_if.source                             out_chan,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lswc_pkg::ApbAddrWidth-1:0] paddr,
  input  wire logic [lswc_pkg::ApbDataWidth-1:0] pwdata,
  output logic      [lswc_pkg::ApbDataWidth-1:0] prdata,
  output logic                                   pready
);

  localparam int unsigned EntryWidth = 2 + 4 * COORD_WIDTH;
  localparam int unsigned DW = lswc_pkg::ApbDataWidth;

  logic [COORD_WIDTH-1:0] win_left_q, win_bottom_q, win_right_q, win_top_q;
  logic [COORD_WIDTH-1:0] rd_sel;
  logic                   wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= '0;
      win_bottom_q <= '0;
      win_right_q  <= '0;
      win_top_q    <= '0;
    end else if (wr_en) begin
      unique case (paddr)
        lswc_pkg::AddrWinLeft:   win_left_q   <= pwdata[COORD_WIDTH-1:0];
        lswc_pkg::AddrWinBottom: win_bottom_q <= pwdata[COORD_WIDTH-1:0];
        lswc_pkg::AddrWinRight:  win_right_q  <= pwdata[COORD_WIDTH-1:0];
        lswc_pkg::AddrWinTop:    win_top_q    <= pwdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      lswc_pkg::AddrWinLeft:   rd_sel = win_left_q;
      lswc_pkg::AddrWinBottom: rd_sel = win_bottom_q;
      lswc_pkg::AddrWinRight:  rd_sel = win_right_q;
      lswc_pkg::AddrWinTop:    rd_sel = win_top_q;
      default:                 rd_sel = '0;
    endcase
  end
  assign prdata = DW'($signed(rd_sel));

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  logic [EntryWidth-1:0] push_data, pop_data;

  lswc_front #(.CoordWidth(COORD_WIDTH)) u_front (
    .in_chan      (in_chan),
    .win_left_i   (win_left_q),
    .win_bottom_i (win_bottom_q),
    .win_right_i  (win_right_q),
    .win_top_i    (win_top_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  lswc_fifo #(.Width(EntryWidth), .Depth(lswc_pkg::QueueDepthDefault)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  lswc_back #(.CoordWidth(COORD_WIDTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .win_left_i   (win_left_q),
    .win_bottom_i (win_bottom_q),
    .win_right_i  (win_right_q),
    .win_top_i    (win_top_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .out_chan     (out_chan)
  );

endmodule
`default_nettype wire

>>> hw/rtl/lswc_front.sv
`default_nettype none
module lswc_front #(
  parameter int unsigned CoordWidth = lswc_pkg::CoordWidthDefault,
  localparam int unsigned EntryWidth = 2 + 4 * CoordWidth
) (
  lswc_in_if.sink                      in_chan,
  input  wire logic [CoordWidth-1:0]   win_left_i,
  input  wire logic [CoordWidth-1:0]   win_bottom_i,
  input  wire logic [CoordWidth-1:0]   win_right_i,
  input  wire logic [CoordWidth-1:0]   win_top_i,
  output logic                         push_valid_o,
  input  wire logic                    push_ready_i,
  output logic [EntryWidth-1:0]        push_data_o
);

  logic [3:0] code_s;
  logic [3:0] code_e;
  lswc_pkg::status_e status;

  always_comb begin
    code_s[lswc_pkg::OcLeft]  = $signed(in_chan.start_x) < $signed(win_left_i);
    code_s[lswc_pkg::OcRight] = $signed(in_chan.start_x) > $signed(win_right_i);
    code_s[lswc_pkg::OcBelow] = $signed(in_chan.start_y) < $signed(win_bottom_i);
    code_s[lswc_pkg::OcAbove] = $signed(in_chan.start_y) > $signed(win_top_i);
    code_e[lswc_pkg::OcLeft]  = $signed(in_chan.end_x) < $signed(win_left_i);
    code_e[lswc_pkg::OcRight] = $signed(in_chan.end_x) > $signed(win_right_i);
    code_e[lswc_pkg::OcBelow] = $signed(in_chan.end_y) < $signed(win_bottom_i);
    code_e[lswc_pkg::OcAbove] = $signed(in_chan.end_y) > $signed(win_top_i);
    if ((code_s | code_e) == 4'd0) begin
      status = lswc_pkg::StatusInside;
    end else if ((code_s & code_e) != 4'd0) begin
      status = lswc_pkg::StatusReject;
    end else begin
      status = lswc_pkg::StatusClipped;
    end
  end

  assign in_chan.ready = push_ready_i;
  assign push_valid_o  = in_chan.valid;
  assign push_data_o   = {status, in_chan.start_x, in_chan.start_y, in_chan.end_x,
                          in_chan.end_y};

endmodule
`default_nettype wire

>>> hw/rtl/lswc_fifo.sv
`default_nettype none
module lswc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = lswc_pkg::QueueDepthDefault,
  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntWidth = $clog2(Depth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [Width-1:0]      pop_data_o
);

  logic [Width-1:0]    mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign push_ready_o = cnt_q != CntWidth'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lswc_back.sv
`default_nettype none
module lswc_back #(
  parameter int unsigned CoordWidth = lswc_pkg::CoordWidthDefault,
  localparam int unsigned EntryWidth = 2 + 4 * CoordWidth
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [CoordWidth-1:0] win_left_i,
  input  wire logic [CoordWidth-1:0] win_bottom_i,
  input  wire logic [CoordWidth-1:0] win_right_i,
  input  wire logic [CoordWidth-1:0] win_top_i,
  input  wire logic                  pop_valid_i,
  output logic                       pop_ready_o,
  input  wire logic [EntryWidth-1:0] pop_data_i,
  lswc_out_if.source                 out_chan
);

  localparam int unsigned W   = CoordWidth;
  localparam int unsigned PaW = 2 * W + 1;
  localparam int unsigned PbW = 2 * W + 2;
  localparam int unsigned SW  = 2 * W + 3;
  localparam int unsigned NW  = 2 * W + 2;
  localparam int unsigned CW  = $clog2(NW + 1);

  lswc_pkg::back_state_e state_q, state_d;

  logic signed [W-1:0] sx_q, sy_q, ex_q, ey_q;
  logic signed [W:0]   dx_q, dy_q;
  logic signed [W-1:0] cur_x_q, cur_y_q, ax_q, ay_q;
  logic                pt_q;
  logic [2:0]          k_q;
  logic                xplane_q;
  logic signed [W-1:0] q0_q;
  logic signed [W:0]   dp_q, dd_q, dq_q;
  logic signed [PaW-1:0] pa_q;
  logic signed [PbW-1:0] pb_q;
  logic [NW-1:0]       num_q;
  logic [W:0]          den_q, rem_q;
  logic [W-1:0]        quo_q;
  logic                neg_q;
  logic [CW-1:0]       cnt_q;
  logic                out_valid_q;
  logic [1:0]          out_status_q;
  logic signed [W-1:0] out_sx_q, out_sy_q, out_ex_q, out_ey_q;

  // entry fields
  logic [1:0]          e_status;
  logic signed [W-1:0] e_sx, e_sy, e_ex, e_ey;
  assign {e_status, e_sx, e_sy, e_ex, e_ey} = pop_data_i;

  logic [3:0] code;
  always_comb begin
    code[lswc_pkg::OcLeft]  = cur_x_q < $signed(win_left_i);
    code[lswc_pkg::OcRight] = cur_x_q > $signed(win_right_i);
    code[lswc_pkg::OcBelow] = cur_y_q < $signed(win_bottom_i);
    code[lswc_pkg::OcAbove] = cur_y_q > $signed(win_top_i);
  end

  logic out_free;
  assign out_free      = !out_valid_q || out_chan.ready;
  assign out_chan.valid           = out_valid_q;
  assign out_chan.status          = out_status_q;
  assign out_chan.clipped_start_x = out_sx_q;
  assign out_chan.clipped_start_y = out_sy_q;
  assign out_chan.clipped_end_x   = out_ex_q;
  assign out_chan.clipped_end_y   = out_ey_q;

  // scan helpers
  logic signed [W-1:0] bnd;
  logic signed [W-1:0] bnd_x, bnd_y;
  assign bnd_x = (k_q[0] == 1'b0) ? $signed(win_left_i) : $signed(win_right_i);
  assign bnd_y = (k_q[0] == 1'b0) ? $signed(win_bottom_i) : $signed(win_top_i);
  assign bnd   = k_q[1] ? bnd_y : bnd_x;

  // multiply and sum
  logic signed [PaW-1:0] pa_d;
  logic signed [PbW-1:0] pb_d;
  logic signed [SW-1:0]  sum;
  logic [SW-1:0]         sum_mag;
  logic [W:0]            dp_mag;
  assign pa_d    = PaW'(q0_q) * PaW'(dp_q);
  assign pb_d    = PbW'(dd_q) * PbW'(dq_q);
  assign sum     = SW'(pa_q) + SW'(pb_q);
  assign sum_mag = sum[SW-1] ? SW'(-sum) : SW'(sum);
  assign dp_mag  = dp_q[W] ? (W+1)'(-dp_q) : (W+1)'(dp_q);

  // one restoring division step
  logic [W+1:0] trial;
  logic         ge;
  logic [W+1:0] trial_sub;
  logic [W-1:0] quo_next;
  logic [W-1:0] quo_final;
  assign trial     = {rem_q, num_q[NW-1]};
  assign ge        = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};
  if (W > 1) begin : g_quo
    assign quo_next = {quo_q[W-2:0], ge};
  end else begin : g_quo1
    assign quo_next = ge;
  end
  assign quo_final = neg_q ? W'(-quo_next) : quo_next;

  always_comb begin
    state_d = state_q;
    pop_ready_o = 1'b0;
    unique case (state_q)
      lswc_pkg::BackIdle: pop_ready_o = (e_status != lswc_pkg::StatusClipped) ? out_free : 1'b1;
      default: pop_ready_o = 1'b0;
    endcase
    unique case (state_q)
      lswc_pkg::BackIdle: begin
        if (pop_valid_i && e_status == lswc_pkg::StatusClipped) begin
          state_d = lswc_pkg::BackScan;
        end
      end
      lswc_pkg::BackScan: begin
        if (k_q[2] || code == 4'd0) begin
          if (pt_q) begin
            state_d = lswc_pkg::BackOut;
          end
        end else if (code[k_q[1:0]]) begin
          if ((k_q[1] == 1'b0 && dx_q != '0) || (k_q[1] == 1'b1 && dy_q != '0)) begin
            state_d = lswc_pkg::BackMul;
          end
        end
      end
      lswc_pkg::BackMul: state_d = lswc_pkg::BackSum;
      lswc_pkg::BackSum: state_d = lswc_pkg::BackDiv;
      lswc_pkg::BackDiv: begin
        if (cnt_q == CW'(1)) begin
          state_d = lswc_pkg::BackScan;
        end
      end
      lswc_pkg::BackOut: begin
        if (out_free) begin
          state_d = lswc_pkg::BackIdle;
        end
      end
      default: state_d = lswc_pkg::BackIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lswc_pkg::BackIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == lswc_pkg::BackIdle && pop_valid_i && pop_ready_o &&
          e_status != lswc_pkg::StatusClipped) begin
        out_valid_q <= 1'b1;
      end else if (state_q == lswc_pkg::BackOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lswc_pkg::BackIdle: begin
        if (pop_valid_i && pop_ready_o) begin
          if (e_status != lswc_pkg::StatusClipped) begin
            out_status_q <= e_status;
            out_sx_q     <= e_sx;
            out_sy_q     <= e_sy;
            out_ex_q     <= e_ex;
            out_ey_q     <= e_ey;
          end else begin
            sx_q    <= e_sx;
            sy_q    <= e_sy;
            ex_q    <= e_ex;
            ey_q    <= e_ey;
            dx_q    <= (W+1)'(e_ex) - (W+1)'(e_sx);
            dy_q    <= (W+1)'(e_ey) - (W+1)'(e_sy);
            cur_x_q <= e_sx;
            cur_y_q <= e_sy;
            pt_q    <= 1'b0;
            k_q     <= '0;
          end
        end
      end
      lswc_pkg::BackScan: begin
        if (k_q[2] || code == 4'd0) begin
          if (!pt_q) begin
            ax_q    <= cur_x_q;
            ay_q    <= cur_y_q;
            cur_x_q <= ex_q;
            cur_y_q <= ey_q;
            pt_q    <= 1'b1;
            k_q     <= '0;
          end
        end else if (!code[k_q[1:0]]) begin
          k_q <= k_q + 1'b1;
        end else begin
          xplane_q <= !k_q[1];
          if (!k_q[1]) begin
            cur_x_q <= bnd;
            q0_q    <= sy_q;
            dp_q    <= dx_q;
            dq_q    <= dy_q;
            dd_q    <= (W+1)'(bnd) - (W+1)'(sx_q);
            if (dx_q == '0) begin
              k_q <= k_q + 1'b1;
            end
          end else begin
            cur_y_q <= bnd;
            q0_q    <= sx_q;
            dp_q    <= dy_q;
            dq_q    <= dx_q;
            dd_q    <= (W+1)'(bnd) - (W+1)'(sy_q);
            if (dy_q == '0) begin
              k_q <= k_q + 1'b1;
            end
          end
        end
      end
      lswc_pkg::BackMul: begin
        pa_q <= pa_d;
        pb_q <= pb_d;
      end
      lswc_pkg::BackSum: begin
        num_q <= sum_mag[NW-1:0];
        neg_q <= sum[SW-1] ^ dp_q[W];
        den_q <= dp_mag;
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= CW'(NW);
      end
      lswc_pkg::BackDiv: begin
        num_q <= {num_q[NW-2:0], 1'b0};
        rem_q <= ge ? trial_sub[W:0] : trial[W:0];
        quo_q <= quo_next;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          k_q <= k_q + 1'b1;
          if (xplane_q) begin
            cur_y_q <= quo_final;
          end else begin
            cur_x_q <= quo_final;
          end
        end
      end
      lswc_pkg::BackOut: begin
        if (out_free) begin
          out_status_q <= lswc_pkg::StatusClipped;
          out_sx_q     <= ax_q;
          out_sy_q     <= ay_q;
          out_ex_q     <= cur_x_q;
          out_ey_q     <= cur_y_q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
